@@ hw/rtl/histogram_intersection_ranker_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Histogram intersection ranker assertion macros
// Shared concurrent assertion forms used by the ranker RTL.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_INTERSECTION_RANKER_UNIT_MACROS_SVH
`define HISTOGRAM_INTERSECTION_RANKER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HIR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("hir assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HIR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("hir assertion failed");

`endif

@@ hw/rtl/hir_pkg.sv @@
// ----------------------------------------------------------------------------
// Histogram intersection ranker package
// Field widths, request and result layouts, and control types.
// ----------------------------------------------------------------------------
package hir_pkg;

	localparam int OP_W    = 2;
	localparam int ID_W    = 16;
	localparam int IDX_W   = 6;
	localparam int VAL_W   = 16;
	localparam int SCORE_W = 22;

	localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

	typedef enum logic [OP_W-1:0] {
		OP_LOAD = 2'd0,
		OP_BIN  = 2'd1,
		OP_EMIT = 2'd2
	} op_t;

	typedef enum logic {
		ST_RUN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [ID_W-1:0]  entry_id;
		logic [IDX_W-1:0] bin_index;
		logic [VAL_W-1:0] bin_value;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0]    result_id;
		logic [SCORE_W-1:0] similarity;
		logic               none_found;
		logic               overflow;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic               valid;
		logic [ID_W-1:0]    id;
		logic [SCORE_W-1:0] score;
	} entry_t;

	typedef struct packed {
		logic               ins;
		logic               emit;
		logic               emit_pending;
		logic [ID_W-1:0]    id;
		logic [SCORE_W-1:0] score;
	} cmd_t;

	typedef struct packed {
		logic               ins;
		logic               shift;
		logic               clear;
		logic [ID_W-1:0]    id;
		logic [SCORE_W-1:0] score;
	} cell_ctl_t;

endpackage

@@ hw/rtl/hir_stream_if.sv @@
// ----------------------------------------------------------------------------
// Histogram intersection ranker stream interface
// Valid and ready handshake carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface hir_stream_if #(parameter type T = logic);

	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

@@ hw/rtl/hir_ram.sv @@
// ----------------------------------------------------------------------------
// Histogram intersection ranker RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module hir_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/hir_score.sv @@
// ----------------------------------------------------------------------------
// Histogram intersection ranker scoring front end
// Holds the query histogram and accumulates min(candidate, query) per bin.
// ----------------------------------------------------------------------------
module hir_score import hir_pkg::*; #(
	parameter int BINS     = 64,
	parameter int BIN_BITS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  take,
	input  req_t  req,
	output cmd_t  cmd
);

	localparam int AW = $clog2(BINS);
	localparam int SW = ((BIN_BITS > SCORE_W) ? BIN_BITS : SCORE_W) + 1;

	logic                in_range;
	logic                is_last;
	logic [BIN_BITS-1:0] val;
	logic                wr;
	logic                rd;
	logic [BIN_BITS-1:0] qbin;

	logic                bin_s1;
	logic                emit_s1;
	logic [BIN_BITS-1:0] val_s1;
	logic [ID_W-1:0]     id_s1;
	logic                last_s1;

	logic [SCORE_W-1:0]  acc_q;
	logic [BIN_BITS-1:0] bin_min;
	logic [SW-1:0]       sum;
	logic [SCORE_W-1:0]  sat;

	logic                ins_s2;
	logic                emit_s2;
	logic [ID_W-1:0]     id_s2;
	logic [SCORE_W-1:0]  score_s2;

	assign in_range = 32'(req.bin_index) < 32'(BINS);
	assign is_last  = 32'(req.bin_index) == 32'(BINS - 1);
	assign val      = BIN_BITS'(req.bin_value);
	assign wr       = take && (req.opcode == OP_LOAD) && in_range;
	assign rd       = take && (req.opcode == OP_BIN) && in_range;

	hir_ram #(
		.WIDTH (BIN_BITS),
		.DEPTH (BINS)
	) u_query_ram (
		.clk   (clk),
		.we    (wr),
		.waddr (AW'(req.bin_index)),
		.wdata (val),
		.re    (rd),
		.raddr (AW'(req.bin_index)),
		.rdata (qbin)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_s1  <= 1'b0;
			emit_s1 <= 1'b0;
		end else begin
			bin_s1  <= rd;
			emit_s1 <= take && (req.opcode == OP_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (rd) begin
			val_s1  <= val;
			id_s1   <= req.entry_id;
			last_s1 <= is_last;
		end
	end

	always_comb begin
		bin_min = (val_s1 < qbin) ? val_s1 : qbin;
		sum     = SW'(acc_q) + SW'(bin_min);
		sat     = (sum > SW'(SCORE_MAX)) ? SCORE_MAX : sum[SCORE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			ins_s2  <= 1'b0;
			emit_s2 <= 1'b0;
		end else begin
			if (bin_s1) begin
				acc_q <= last_s1 ? '0 : sat;
			end
			ins_s2  <= bin_s1 && last_s1;
			emit_s2 <= emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (bin_s1 && last_s1) begin
			id_s2    <= id_s1;
			score_s2 <= sat;
		end
	end

	assign cmd.ins          = ins_s2;
	assign cmd.emit         = emit_s2;
	assign cmd.emit_pending = emit_s1;
	assign cmd.id           = id_s2;
	assign cmd.score        = score_s2;

endmodule

@@ hw/rtl/hir_cell.sv @@
// ----------------------------------------------------------------------------
// Histogram intersection ranker table cell
// One place of the sorted table; inserts by shifting down, emits by shifting up.
// ----------------------------------------------------------------------------
module hir_cell import hir_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  entry_t    up,
	input  logic      up_keep,
	input  entry_t    down,
	output entry_t    cur,
	output logic      keep
);

	logic               valid_q;
	logic [ID_W-1:0]    id_q;
	logic [SCORE_W-1:0] score_q;

	// Equal scores stay ahead, so ties leave in arrival order.
	assign keep = valid_q && (score_q >= ctl.score);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			priority if (ctl.clear) begin
				valid_q <= 1'b0;
			end else if (ctl.shift) begin
				valid_q <= down.valid;
			end else if (ctl.ins && !keep) begin
				valid_q <= up_keep ? 1'b1 : up.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (ctl.shift) begin
			id_q    <= down.id;
			score_q <= down.score;
		end else if (ctl.ins && !keep) begin
			id_q    <= up_keep ? ctl.id : up.id;
			score_q <= up_keep ? ctl.score : up.score;
		end
	end

	assign cur.valid = valid_q;
	assign cur.id    = id_q;
	assign cur.score = score_q;

endmodule

@@ hw/rtl/histogram_intersection_ranker_unit.sv @@
// ----------------------------------------------------------------------------
// Histogram intersection ranker
// Scores candidate histograms against a query and emits them ranked.
// ----------------------------------------------------------------------------
// Query loads and candidate bins are taken one per cycle while req.ready is
// high. A candidate's score passes the hir_score s1 and s2 stages after its
// last bin is accepted and reaches the sorted table, where every cell compares
// it with its own entry and the table shifts down by one place. An emit request
// holds off further requests while it passes emit_s1 and emit_s2 and the bin
// pipeline drains, then the table shifts one entry per cycle into the one-deep
// result register whenever that register is free. Requests are accepted again
// once the final result has been loaded.
`include "histogram_intersection_ranker_unit_macros.svh"

module histogram_intersection_ranker_unit import hir_pkg::*; #(
	parameter int BINS        = 64,
	parameter int MAX_ENTRIES = 64,
	parameter int BIN_BITS    = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [SCORE_W-1:0] cfg_wdata,
	hir_stream_if.sink         req,
	hir_stream_if.source       rsp
);

	logic [SCORE_W-1:0] threshold_q;
	state_t             state_q;
	state_t             state_d;
	cmd_t               cmd;
	cell_ctl_t          ctl;
	entry_t             cells [MAX_ENTRIES];
	logic               keep  [MAX_ENTRIES];
	logic               take;
	logic               full;
	logic               dropped_q;
	logic               head_pass;
	logic               next_pass;
	logic               slot_free;
	logic               load;
	rsp_t               load_data;
	logic               out_valid_q;
	rsp_t               out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	assign req.ready = (state_q == ST_RUN) && !cmd.emit && !cmd.emit_pending;
	assign take      = req.valid && req.ready;

	hir_score #(
		.BINS     (BINS),
		.BIN_BITS (BIN_BITS)
	) u_score (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.req    (req.data),
		.cmd    (cmd)
	);

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		entry_t up;
		logic   up_keep;
		entry_t down;

		if (i == 0) begin : g_head
			assign up      = '0;
			assign up_keep = 1'b1;
		end else begin : g_body
			assign up      = cells[i-1];
			assign up_keep = keep[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_tail
			assign down = '0;
		end else begin : g_inner
			assign down = cells[i+1];
		end

		hir_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.up      (up),
			.up_keep (up_keep),
			.down    (down),
			.cur     (cells[i]),
			.keep    (keep[i])
		);
	end

	assign full      = cells[MAX_ENTRIES-1].valid;
	assign head_pass = cells[0].valid && (cells[0].score > threshold_q);
	assign next_pass = cells[1].valid && (cells[1].score > threshold_q);
	assign slot_free = !out_valid_q || rsp.ready;

	always_comb begin
		state_d   = state_q;
		ctl.ins   = cmd.ins && !full;
		ctl.shift = 1'b0;
		ctl.clear = 1'b0;
		ctl.id    = cmd.id;
		ctl.score = cmd.score;
		load      = 1'b0;
		load_data = '0;
		unique case (state_q)
			ST_RUN: begin
				if (cmd.emit) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					load               = 1'b1;
					load_data.overflow = dropped_q;
					if (head_pass) begin
						load_data.result_id  = cells[0].id;
						load_data.similarity = cells[0].score;
						load_data.last       = !next_pass;
					end else begin
						load_data.none_found = 1'b1;
						load_data.last       = 1'b1;
					end
					if (head_pass && next_pass) begin
						ctl.shift = 1'b1;
					end else begin
						ctl.clear = 1'b1;
						state_d   = ST_RUN;
					end
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.clear) begin
				dropped_q <= 1'b0;
			end else if (cmd.ins && full) begin
				dropped_q <= 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= load_data;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_data_q;

	`HIR_ASSERT_IMP(a_no_req_in_emit, clk, arst_n, state_q == ST_EMIT, !req.ready)
	`HIR_ASSERT_NXT(a_last_ends_emit, clk, arst_n, load && load_data.last, state_q == ST_RUN)
	`HIR_ASSERT_IMP(a_head_sorted, clk, arst_n, cells[1].valid, cells[0].valid && (cells[0].score >= cells[1].score))
	`HIR_ASSERT_NXT(a_drop_marked, clk, arst_n, cmd.ins && full, dropped_q)

endmodule

@@ sim/tb_histogram_intersection_ranker_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Histogram intersection ranker testbench
// Loads a query, streams directed and random candidates with noise and
// broken sequences, and checks every emitted ranking against a predictor.
// Both handshake sides idle at random, and the result side stalls for a long
// stretch once so that the result register stays full and the block holds off further requests.
// ----------------------------------------------------------------------------
module tb_histogram_intersection_ranker_unit;
	import hir_pkg::*;

	localparam int                 BIN_COUNT      = 64;
	localparam int                 TABLE_DEPTH    = 64;
	localparam int                 NOISE_BINS     = 8;
	localparam logic [IDX_W-1:0]   LAST_BIN       = IDX_W'(BIN_COUNT - 1);
	localparam logic [OP_W-1:0]    OP_UNUSED      = 2'd3;
	localparam int                 SETTLE_CYCLES  = 8;
	localparam int                 HOLD_CYCLES    = 300;
	localparam int                 WATCHDOG_LIMIT = 2000;

	class ranking_tracker;
		logic [VAL_W-1:0]   query_bins [BIN_COUNT];
		logic [SCORE_W-1:0] running_score;
		logic [ID_W-1:0]    ranked_ids [$];
		logic [SCORE_W-1:0] ranked_scores [$];
		logic               dropped;
		logic [SCORE_W-1:0] threshold;
		rsp_t               expected_rankings [$];
		int                 errors, requests, results, emits;
		int                 empty_emits, overflow_emits, saturations;

		function new();
			foreach (query_bins[i]) query_bins[i] = '0;
			running_score = '0;
			dropped       = 1'b0;
			threshold     = '0;
			errors        = 0;
			requests      = 0;
			results       = 0;
			emits         = 0;
			empty_emits   = 0;
			overflow_emits = 0;
			saturations   = 0;
		endfunction

		function void note_request(req_t r);
			logic [SCORE_W+1:0] sum;
			logic [VAL_W-1:0]   overlap;
			rsp_t               res;
			int                 pos;
			requests++;
			case (r.opcode)
			OP_LOAD: begin
				query_bins[r.bin_index] = r.bin_value;
			end
			OP_BIN: begin
				overlap = (r.bin_value < query_bins[r.bin_index]) ?
					r.bin_value : query_bins[r.bin_index];
				sum = running_score + overlap;
				if (sum > SCORE_MAX) begin
					sum = SCORE_MAX;
					saturations++;
				end
				running_score = sum[SCORE_W-1:0];
				if (r.bin_index == LAST_BIN) begin
					if (ranked_scores.size() >= TABLE_DEPTH) begin
						dropped = 1'b1;
					end else begin
						pos = 0;
						while (pos < ranked_scores.size() && ranked_scores[pos] >= running_score)
							pos++;
						ranked_ids.insert(pos, r.entry_id);
						ranked_scores.insert(pos, running_score);
					end
					running_score = '0;
				end
			end
			OP_EMIT: begin
				emits++;
				if (dropped) overflow_emits++;
				pos = 0;
				while (pos < ranked_scores.size() && ranked_scores[pos] > threshold) begin
					res            = '0;
					res.result_id  = ranked_ids[pos];
					res.similarity = ranked_scores[pos];
					res.overflow   = dropped;
					expected_rankings.push_back(res);
					pos++;
				end
				if (pos == 0) begin
					empty_emits++;
					res            = '0;
					res.none_found = 1'b1;
					res.overflow   = dropped;
					res.last       = 1'b1;
					expected_rankings.push_back(res);
				end else begin
					res      = expected_rankings.pop_back();
					res.last = 1'b1;
					expected_rankings.push_back(res);
				end
				ranked_ids.delete();
				ranked_scores.delete();
				dropped = 1'b0;
			end
			default: begin
			end
			endcase
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (expected_rankings.size() == 0) begin
				$error("Unexpected result: id %0d, similarity %0d", got.result_id, got.similarity);
				errors++;
				return;
			end
			want = expected_rankings.pop_front();
			results++;
			if (got.result_id !== want.result_id) begin
				$error("result_id: expected %0d, got %0d", want.result_id, got.result_id);
				errors++;
			end
			if (got.similarity !== want.similarity) begin
				$error("similarity: expected %0d, got %0d", want.similarity, got.similarity);
				errors++;
			end
			if (got.none_found !== want.none_found) begin
				$error("none_found: expected %0b, got %0b", want.none_found, got.none_found);
				errors++;
			end
			if (got.overflow !== want.overflow) begin
				$error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [SCORE_W-1:0] cfg_wdata;
	bit                 steady_flow;
	bit                 hold_results;
	int                 quiet_cycles;

	hir_stream_if #(.T(req_t)) req_if ();
	hir_stream_if #(.T(rsp_t)) rsp_if ();

	ranking_tracker tracker = new();

	histogram_intersection_ranker_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady_flow || roll < 60) return 0;
		if (roll < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 3))
		0: return '0;
		1: return '1;
		2: return VAL_W'($urandom_range(0, 15));
		default: return VAL_W'($urandom);
		endcase
	endfunction

	task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
			input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
		req_t r;
		int   gap;
		r   = '{opcode: op, entry_id: id, bin_index: idx, bin_value: val};
		gap = pick_gap();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= r;
		do begin
			@(posedge clk);
		end while (!req_if.ready);
	endtask

	task automatic send_emit();
		send_request(OP_EMIT, ID_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
	endtask

	task automatic send_candidate(input logic [ID_W-1:0] id, input bit full_sweep);
		if (full_sweep) begin
			for (int i = 0; i < NOISE_BINS; i++)
				send_request(OP_BIN, ID_W'($urandom), IDX_W'(i), pick_value());
		end else begin
			repeat ($urandom_range(0, 3))
				send_request(OP_BIN, ID_W'($urandom),
					IDX_W'($urandom_range(0, NOISE_BINS - 1)), pick_value());
		end
		send_request(OP_BIN, id, LAST_BIN, pick_value());
	endtask

	task automatic settle();
		req_if.valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (tracker.expected_rankings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [SCORE_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		tracker.threshold = value;
	endtask

	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			if (hold_results) begin
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_results = 1'b0;
			end else begin
				if (pick_gap() > 0) begin
					rsp_if.ready <= 1'b0;
					repeat (pick_gap() + 1) @(posedge clk);
				end
				rsp_if.ready <= 1'b1;
				do begin
					@(posedge clk);
				end while (!rsp_if.valid && !hold_results);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && req_if.valid && req_if.ready) tracker.note_request(req_if.data);
		if (arst_n && rsp_if.valid && rsp_if.ready) tracker.check_result(rsp_if.data);
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			quiet_cycles = 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: nothing moved for %0d cycles", quiet_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles++;
		end
	end

	initial begin
		logic [VAL_W-1:0]   qval;
		logic [SCORE_W-1:0] limit_score;
		int                 candidates;
		int                 request_goal;
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_wdata    <= '0;
		req_if.valid <= 1'b0;
		req_if.data  <= '0;
		steady_flow  = 1'b0;
		hold_results = 1'b0;
		quiet_cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(OP_EMIT, '1, '1, '1);
		for (int i = 0; i < NOISE_BINS; i++) begin
			case (i)
			0: qval = '0;
			1: qval = '1;
			2: qval = VAL_W'(1);
			default: qval = VAL_W'($urandom);
			endcase
			send_request(OP_LOAD, ID_W'($urandom), IDX_W'(i), qval);
		end
		send_request(OP_LOAD, ID_W'($urandom), LAST_BIN, '1);
		send_request(OP_UNUSED, '1, '1, '1);
		send_request(OP_BIN, 16'h0000, LAST_BIN, '1);
		send_request(OP_BIN, 16'hFFFF, LAST_BIN, '1);
		send_request(OP_BIN, 16'h1234, LAST_BIN, '0);
		repeat (2) send_request(OP_BIN, 16'h0042, IDX_W'(5), VAL_W'(1000));
		send_request(OP_EMIT, '0, '0, '0);
		send_request(OP_BIN, 16'h0042, LAST_BIN, VAL_W'(7));
		settle();

		write_threshold(SCORE_MAX);
		send_request(OP_BIN, 16'h5A5A, LAST_BIN, '1);
		send_emit();
		settle();

		write_threshold('0);
		repeat (TABLE_DEPTH + 1) send_request(OP_BIN, ID_W'($urandom), LAST_BIN, pick_value());
		send_emit();
		settle();

		request_goal = tracker.requests + 44;
		for (int phase = 0; phase < 40 && tracker.requests < request_goal; phase++) begin
			steady_flow = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 3))
			0: limit_score = '0;
			1: limit_score = SCORE_MAX;
			2: limit_score = SCORE_W'($urandom_range(0, 400000));
			default: limit_score = SCORE_W'($urandom_range(0, 2500000));
			endcase
			if (phase == 0) limit_score = '0;
			write_threshold(limit_score);
			candidates = (phase == 0) ? 6 : $urandom_range(1, 8);
			for (int c = 0; c < candidates; c++) begin
				if ($urandom_range(0, 9) == 0) begin
					case ($urandom_range(0, 2))
					0: send_request(OP_UNUSED, ID_W'($urandom), IDX_W'($urandom),
						VAL_W'($urandom));
					1: send_request(OP_LOAD, ID_W'($urandom), IDX_W'($urandom), pick_value());
					default: send_emit();
					endcase
				end
				send_candidate(ID_W'($urandom), $urandom_range(0, 7) == 0);
			end
			if (phase == 0) begin
				// The result side stops while requests keep coming behind the emit.
				hold_results = 1'b1;
				send_emit();
				repeat (3) send_candidate(ID_W'($urandom), 1'b0);
			end else if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 3))
					send_request(OP_BIN, ID_W'($urandom),
						IDX_W'($urandom_range(0, NOISE_BINS - 1)), pick_value());
			end
			send_emit();
			settle();
		end

		repeat (20) @(posedge clk);
		$display("Covered %0d requests and %0d ranked results over %0d emits.",
			tracker.requests, tracker.results, tracker.emits);
		$display("%0d emits found nothing above the threshold, %0d reported dropped entries, %0d sums saturated.",
			tracker.empty_emits, tracker.overflow_emits, tracker.saturations);
		if (tracker.errors == 0 && tracker.expected_rankings.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
